### hdl/event_stream_data_line_parser_assert.svh
// assertion macros for the event-stream data line parser checker
// expects i_clk and i_rst_n to be visible where the macros are used
`ifndef EVENT_STREAM_DATA_LINE_PARSER_ASSERT_SVH
`define EVENT_STREAM_DATA_LINE_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESDLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ESDLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/esdlp_pkg.sv
// shared types and constants for the event-stream data line parser
// used by esdlp_class and the top level; no dependencies
package esdlp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef enum logic [3:0] {
        CLS_START     = 4'd0,
        CLS_D         = 4'd1,
        CLS_DA        = 4'd2,
        CLS_DAT       = 4'd3,
        CLS_DATA      = 4'd4,
        CLS_DATA_LINE = 4'd5,
        CLS_IGNORE    = 4'd7
    } t_line_class;

    // what a line byte does to the payload side
    typedef struct packed {
        logic push;
        logic set_started;
    } t_byte_act;

endpackage

### hdl/esdlp_class.sv
// line classifier: matches the "data:" prefix and decides payload bytes
// depends on esdlp_pkg
module esdlp_class
    import esdlp_pkg::*;
(
    input  t_line_class i_class,
    input  logic [7:0]  i_byte,
    input  logic        i_started,
    output t_line_class o_class,
    output t_byte_act   o_act
);

    always_comb begin
        o_class = CLS_IGNORE;
        o_act   = '0;
        case (i_class)
            CLS_START: begin
                o_class = (i_byte == CH_D) ? CLS_D : CLS_IGNORE;
            end
            CLS_D: begin
                o_class = (i_byte == CH_A) ? CLS_DA : CLS_IGNORE;
            end
            CLS_DA: begin
                o_class = (i_byte == CH_T) ? CLS_DAT : CLS_IGNORE;
            end
            CLS_DAT: begin
                o_class = (i_byte == CH_A) ? CLS_DATA : CLS_IGNORE;
            end
            CLS_DATA: begin
                o_class = (i_byte == CH_COLON) ? CLS_DATA_LINE : CLS_IGNORE;
            end
            CLS_DATA_LINE: begin
                o_class           = CLS_DATA_LINE;
                o_act.set_started = !i_started;
                // one leading space right after the colon is dropped
                o_act.push        = i_started || (i_byte != CH_SP);
            end
            default: begin
                o_class = CLS_IGNORE;
            end
        endcase
    end

endmodule

### hdl/event_stream_data_line_parser.sv
// top level of the event-stream data line parser: sequencer and payload store
// depends on esdlp_pkg and esdlp_class
//
// Input channel: i_valid/o_stall with i_action and i_in_byte. Action 0 feeds
// one stream byte, action 1 ends the stream and closes a pending event.
// Output channel: o_valid/i_stall with o_out_byte, o_end_of_event,
// o_line_truncated and o_last_of_run (set on the last result of a request).
// A byte other than carriage return that follows a held carriage return on
// a data line passes through S_WR2 (two writes through the one store write
// port). At a line feed the separator or end marker is shown in the next
// cycle; each stored payload byte is then read from the store in S_RD and
// presented in S_OUT. o_stall stays high while results are pending; a stall
// on the output simply holds the current result and freezes the sequencer.
// Synchronous reset returns to line start with an empty event; the payload
// store is not cleared and needs no clearing pass, since only bytes written
// on the current line are ever read back.
module event_stream_data_line_parser
    import esdlp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_event,
    output logic       o_line_truncated,
    output logic       o_last_of_run
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int LW = $clog2(PAYLOAD_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR2,
        S_RD,
        S_OUT
    } t_state;

    t_state        r_state;
    t_line_class   r_class;
    logic [1:0]    r_char_cnt;
    logic          r_first_cr;
    logic [LW-1:0] r_plen;
    logic          r_started;
    logic          r_ovf;
    logic          r_has_content;
    logic          r_held_cr;
    logic [7:0]    r_pend;
    logic [LW-1:0] r_rep_len;
    logic [LW-1:0] r_idx;
    logic          r_rep_trunc;
    logic [7:0]    r_out_byte;
    logic          r_end;
    logic          r_trunc;
    logic          r_last;
    logic [7:0]    r_mem [PAYLOAD_DEPTH];

    t_line_class   n_class;
    t_byte_act     byte_act;
    logic          accept;
    logic          is_byte;
    logic          is_lf;
    logic          blank;
    logic          wr_req;
    logic [7:0]    wr_data;
    logic          has_room;

    esdlp_class u_class (
        .i_class   (r_class),
        .i_byte    (i_in_byte),
        .i_started (r_started),
        .o_class   (n_class),
        .o_act     (byte_act)
    );

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_out_byte       = r_out_byte;
    assign o_end_of_event   = r_end;
    assign o_line_truncated = r_trunc;
    assign o_last_of_run    = r_last;

    assign accept   = i_valid && !o_stall;
    assign is_lf    = (i_in_byte == CH_LF);
    assign is_byte  = accept && !i_action && !is_lf;
    assign blank    = (r_char_cnt == 2'd0) || ((r_char_cnt == 2'd1) && r_first_cr);
    assign has_room = (r_plen < LW'(PAYLOAD_DEPTH));

    // store write request: a held CR goes first, the new byte follows in S_WR2
    always_comb begin
        wr_req  = 1'b0;
        wr_data = r_pend;
        if (r_state == S_WR2) begin
            wr_req = 1'b1;
        end else if (is_byte && byte_act.push) begin
            wr_req  = r_held_cr || (i_in_byte != CH_CR);
            wr_data = r_held_cr ? CH_CR : i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_req && has_room) begin
            r_mem[r_plen[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_class       <= CLS_START;
            r_char_cnt    <= 2'd0;
            r_first_cr    <= 1'b0;
            r_plen        <= '0;
            r_started     <= 1'b0;
            r_ovf         <= 1'b0;
            r_has_content <= 1'b0;
            r_held_cr     <= 1'b0;
        end else begin
            if (wr_req) begin
                if (has_room) begin
                    r_plen <= r_plen + LW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_action || is_lf) begin
                            // line clear
                            r_class    <= CLS_START;
                            r_char_cnt <= 2'd0;
                            r_first_cr <= 1'b0;
                            r_plen     <= '0;
                            r_started  <= 1'b0;
                            r_ovf      <= 1'b0;
                            r_held_cr  <= 1'b0;
                        end
                        if (i_action || (is_lf && blank)) begin
                            if (r_has_content) begin
                                r_out_byte    <= 8'd0;
                                r_end         <= 1'b1;
                                r_trunc       <= 1'b0;
                                r_last        <= 1'b1;
                                r_has_content <= 1'b0;
                                r_state       <= S_OUT;
                            end
                        end else if (is_lf) begin
                            if (r_class == CLS_DATA_LINE) begin
                                r_rep_len   <= r_plen;
                                r_rep_trunc <= r_ovf;
                                r_idx       <= '0;
                                if (r_plen != '0) begin
                                    r_has_content <= 1'b1;
                                end
                                if (r_has_content) begin
                                    r_out_byte <= CH_LF;
                                    r_end      <= 1'b0;
                                    r_trunc    <= r_ovf;
                                    r_last     <= (r_plen == '0);
                                    r_state    <= S_OUT;
                                end else if (r_plen != '0) begin
                                    r_state <= S_RD;
                                end
                            end
                        end else begin
                            if ((r_char_cnt == 2'd0) && (i_in_byte == CH_CR)) begin
                                r_first_cr <= 1'b1;
                            end
                            if (r_char_cnt != 2'd3) begin
                                r_char_cnt <= r_char_cnt + 2'd1;
                            end
                            r_class <= n_class;
                            if (byte_act.set_started) begin
                                r_started <= 1'b1;
                            end
                            if (byte_act.push) begin
                                r_held_cr <= (i_in_byte == CH_CR);
                                r_pend    <= i_in_byte;
                                if (r_held_cr && (i_in_byte != CH_CR)) begin
                                    r_state <= S_WR2;
                                end
                            end
                        end
                    end
                end
                S_WR2: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_out_byte <= r_mem[r_idx[AW-1:0]];
                    r_end      <= 1'b0;
                    r_trunc    <= r_rep_trunc;
                    r_last     <= ((r_idx + LW'(1)) == r_rep_len);
                    r_idx      <= r_idx + LW'(1);
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= r_last ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/esdlp_checker.sv
// port-level checker for the event-stream data line parser, bound to the top
// depends on event_stream_data_line_parser_assert.svh
`include "event_stream_data_line_parser_assert.svh"

module esdlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_action,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_end_of_event,
    input logic       o_line_truncated,
    input logic       o_last_of_run
);

    // an end marker carries no byte, no truncation and closes the request
    `ESDLP_ASSERT_NOW(a_end_marker, o_valid && o_end_of_event, (o_out_byte == 8'd0) && !o_line_truncated && o_last_of_run, "end marker malformed")

    // no new request is taken while a result is pending
    `ESDLP_ASSERT_NOW(a_busy_while_out, o_valid, o_stall, "ready while result pending")

    // after the last result is taken the block is ready again
    `ESDLP_ASSERT_NEXT(a_ready_after_last, o_valid && !i_stall && o_last_of_run, !o_stall && !o_valid, "not ready after last result")

    // a stalled result holds its payload
    `ESDLP_ASSERT_NEXT(a_hold_on_stall, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_end_of_event) && $stable(o_last_of_run), "stalled result changed")

    // a stream end gives nothing but an end marker
    `ESDLP_ASSERT_NEXT(a_flush_result, i_valid && !o_stall && i_action, !o_valid || (o_end_of_event && o_last_of_run), "stream end gave a data result")

endmodule

bind event_stream_data_line_parser esdlp_checker u_esdlp_checker (.*);
